// ===== hw/rtl/rvie_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvie_pkg
// Shared types and constants of the RV64I I-type execute block.
// ----------------------------------------------------------------------------
package rvie_pkg;

    localparam int          MEM_BYTES_DEF = 4096;
    localparam logic [63:0] WINDOW_BASE   = 64'h0000_0000_0001_0000;
    localparam logic [4:0]  REG_ZERO      = 5'd0;
    localparam int          QDEPTH        = 2;

    typedef enum logic [4:0] {
        REQ_ADDI    = 5'd0,
        REQ_XORI    = 5'd1,
        REQ_ORI     = 5'd2,
        REQ_ANDI    = 5'd3,
        REQ_SLLI    = 5'd4,
        REQ_SRLI    = 5'd5,
        REQ_SRAI    = 5'd6,
        REQ_LB      = 5'd7,
        REQ_LH      = 5'd8,
        REQ_LW      = 5'd9,
        REQ_LD      = 5'd10,
        REQ_LBU     = 5'd11,
        REQ_LHU     = 5'd12,
        REQ_LWU     = 5'd13,
        REQ_JALR    = 5'd14,
        REQ_SETREG  = 5'd15,
        REQ_MEMBYTE = 5'd16
    } req_t;

    typedef enum logic [3:0] {
        CL_ADD, CL_XOR, CL_OR, CL_AND, CL_SLL, CL_SRL, CL_SRA,
        CL_LOAD, CL_JALR, CL_SET, CL_MEMW, CL_NOP
    } op_class_t;

    typedef enum logic [1:0] {SZ_B, SZ_H, SZ_W, SZ_D} ld_size_t;

    typedef struct packed {
        op_class_t          cls;
        ld_size_t           size;
        logic               sgn;
        logic               wr;
        logic [4:0]         rd;
        logic [4:0]         rs;
        logic signed [11:0] imm;
        logic [19:0]        line;
        logic [63:0]        lv;
        logic [11:0]        midx;
    } item_t;

    typedef struct packed {
        logic clearing;
    } back_status_t;

    typedef enum logic [2:0] {
        B_CLEAR, B_IDLE, B_ADDR, B_EXEC, B_LOAD, B_LWAIT, B_JALR
    } back_state_t;

endpackage

// ===== hw/rtl/rvie_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvie_front
// Accepts request beats and classifies them into queue entries.
// ----------------------------------------------------------------------------
module rvie_front (
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [4:0]           s_req_type,
    input  logic [4:0]           s_dest_reg,
    input  logic [4:0]           s_src_reg,
    input  logic signed [11:0]   s_immediate,
    input  logic [19:0]          s_line_index,
    input  logic signed [63:0]   s_load_value,
    input  logic [11:0]          s_mem_index,
    input  logic                 q_full,
    input  rvie_pkg::back_status_t bstat,
    output logic                 q_push,
    output rvie_pkg::item_t      q_item
);

    logic writes;

    assign s_ready = !q_full && !bstat.clearing;
    assign q_push  = s_valid && s_ready;

    always_comb begin
        q_item.cls  = rvie_pkg::CL_NOP;
        q_item.size = rvie_pkg::SZ_B;
        q_item.sgn  = 1'b0;
        writes      = 1'b1;
        unique case (s_req_type)
            rvie_pkg::REQ_ADDI:    q_item.cls = rvie_pkg::CL_ADD;
            rvie_pkg::REQ_XORI:    q_item.cls = rvie_pkg::CL_XOR;
            rvie_pkg::REQ_ORI:     q_item.cls = rvie_pkg::CL_OR;
            rvie_pkg::REQ_ANDI:    q_item.cls = rvie_pkg::CL_AND;
            rvie_pkg::REQ_SLLI:    q_item.cls = rvie_pkg::CL_SLL;
            rvie_pkg::REQ_SRLI:    q_item.cls = rvie_pkg::CL_SRL;
            rvie_pkg::REQ_SRAI:    q_item.cls = rvie_pkg::CL_SRA;
            rvie_pkg::REQ_LB: begin
                q_item.cls = rvie_pkg::CL_LOAD; q_item.size = rvie_pkg::SZ_B; q_item.sgn = 1'b1;
            end
            rvie_pkg::REQ_LH: begin
                q_item.cls = rvie_pkg::CL_LOAD; q_item.size = rvie_pkg::SZ_H; q_item.sgn = 1'b1;
            end
            rvie_pkg::REQ_LW: begin
                q_item.cls = rvie_pkg::CL_LOAD; q_item.size = rvie_pkg::SZ_W; q_item.sgn = 1'b1;
            end
            rvie_pkg::REQ_LD: begin
                q_item.cls = rvie_pkg::CL_LOAD; q_item.size = rvie_pkg::SZ_D;
            end
            rvie_pkg::REQ_LBU: begin
                q_item.cls = rvie_pkg::CL_LOAD; q_item.size = rvie_pkg::SZ_B;
            end
            rvie_pkg::REQ_LHU: begin
                q_item.cls = rvie_pkg::CL_LOAD; q_item.size = rvie_pkg::SZ_H;
            end
            rvie_pkg::REQ_LWU: begin
                q_item.cls = rvie_pkg::CL_LOAD; q_item.size = rvie_pkg::SZ_W;
            end
            rvie_pkg::REQ_JALR:    q_item.cls = rvie_pkg::CL_JALR;
            rvie_pkg::REQ_SETREG:  q_item.cls = rvie_pkg::CL_SET;
            rvie_pkg::REQ_MEMBYTE: begin
                q_item.cls = rvie_pkg::CL_MEMW; writes = 1'b0;
            end
            default: writes = 1'b0;
        endcase
        q_item.wr   = writes && (s_dest_reg != rvie_pkg::REG_ZERO);
        q_item.rd   = s_dest_reg;
        q_item.rs   = s_src_reg;
        q_item.imm  = s_immediate;
        q_item.line = s_line_index;
        q_item.lv   = s_load_value;
        q_item.midx = s_mem_index;
    end

endmodule

// ===== hw/rtl/rvie_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvie_queue
// Two-entry queue of classified items between front and back.
// ----------------------------------------------------------------------------
module rvie_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  rvie_pkg::item_t push_item,
    input  logic            pop,
    output logic            full,
    output logic            not_empty,
    output rvie_pkg::item_t head
);

    localparam int PW = $clog2(rvie_pkg::QDEPTH);

    rvie_pkg::item_t      ent_reg [rvie_pkg::QDEPTH];
    logic [PW-1:0]        wptr_reg, rptr_reg;
    logic [PW:0]          cnt_reg;

    assign full      = (cnt_reg == (PW+1)'(rvie_pkg::QDEPTH));
    assign not_empty = (cnt_reg != '0);
    assign head      = ent_reg[rptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            ent_reg[wptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            if (push) wptr_reg <= wptr_reg + 1'b1;
            if (pop)  rptr_reg <= rptr_reg + 1'b1;
            cnt_reg <= cnt_reg + (PW+1)'(push) - (PW+1)'(pop);
        end
    end

endmodule

// ===== hw/rtl/rvie_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvie_back
// Executes queued items: register file, byte store, result register.
// ----------------------------------------------------------------------------
module rvie_back #(
    parameter int MEM_BYTES = rvie_pkg::MEM_BYTES_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   q_not_empty,
    input  rvie_pkg::item_t        q_head,
    output logic                   q_pop,
    output rvie_pkg::back_status_t bstat,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic                   m_reg_written,
    output logic [4:0]             m_written_reg,
    output logic signed [63:0]     m_written_value,
    output logic signed [63:0]     m_jump_offset
);

    localparam int AW = (MEM_BYTES > 1) ? $clog2(MEM_BYTES) : 1;

    rvie_pkg::back_state_t state_reg, state_next;
    rvie_pkg::item_t       it_reg;
    logic [63:0]           rf_reg [32];
    logic [7:0]            mem [MEM_BYTES];
    logic [63:0]           a_reg, ea_reg, d_reg, acc_reg;
    logic [AW-1:0]         clr_reg;
    logic [2:0]            cnt_reg, pidx_reg, last_cnt;
    logic                  pend_reg, pin_reg;
    logic [7:0]            rdata_reg;
    logic                  out_v_reg, out_w_reg;
    logic [4:0]            out_r_reg;
    logic [63:0]           out_val_reg, out_off_reg;

    logic                  fin, mem_we, mem_re, in_range;
    logic [AW-1:0]         mem_wa;
    logic [7:0]            mem_wd;
    logic [63:0]           rel, fin_val, fin_off, acc_next, ldv;

    assign bstat.clearing  = (state_reg == rvie_pkg::B_CLEAR);
    assign q_pop           = (state_reg == rvie_pkg::B_IDLE) && q_not_empty && !out_v_reg;
    assign m_valid         = out_v_reg;
    assign m_reg_written   = out_w_reg;
    assign m_written_reg   = out_r_reg;
    assign m_written_value = out_val_reg;
    assign m_jump_offset   = out_off_reg;

    always_comb begin
        unique case (it_reg.size)
            rvie_pkg::SZ_B: last_cnt = 3'd0;
            rvie_pkg::SZ_H: last_cnt = 3'd1;
            rvie_pkg::SZ_W: last_cnt = 3'd3;
            rvie_pkg::SZ_D: last_cnt = 3'd7;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            rvie_pkg::B_CLEAR: if (clr_reg == AW'(MEM_BYTES - 1)) state_next = rvie_pkg::B_IDLE;
            rvie_pkg::B_IDLE:  if (q_pop) state_next = rvie_pkg::B_ADDR;
            rvie_pkg::B_ADDR: begin
                priority if (it_reg.cls == rvie_pkg::CL_LOAD) state_next = rvie_pkg::B_LOAD;
                else state_next = rvie_pkg::B_EXEC;
            end
            rvie_pkg::B_EXEC: begin
                priority if (it_reg.cls == rvie_pkg::CL_JALR) state_next = rvie_pkg::B_JALR;
                else state_next = rvie_pkg::B_IDLE;
            end
            rvie_pkg::B_LOAD:  if (cnt_reg == last_cnt) state_next = rvie_pkg::B_LWAIT;
            rvie_pkg::B_LWAIT: state_next = rvie_pkg::B_IDLE;
            rvie_pkg::B_JALR:  state_next = rvie_pkg::B_IDLE;
            default:           state_next = rvie_pkg::B_CLEAR;
        endcase
    end

    always_comb begin
        rel      = ea_reg - rvie_pkg::WINDOW_BASE + 64'(cnt_reg);
        in_range = (rel < 64'(MEM_BYTES));
        mem_re   = (state_reg == rvie_pkg::B_LOAD) && in_range;
        mem_we   = 1'b0;
        mem_wa   = clr_reg;
        mem_wd   = 8'h00;
        if (state_reg == rvie_pkg::B_CLEAR) begin
            mem_we = 1'b1;
        end else if (state_reg == rvie_pkg::B_EXEC && it_reg.cls == rvie_pkg::CL_MEMW
                     && 64'(it_reg.midx) < 64'(MEM_BYTES)) begin
            mem_we = 1'b1;
            mem_wa = AW'(it_reg.midx);
            mem_wd = it_reg.lv[7:0];
        end

        acc_next = acc_reg;
        if (pend_reg) begin
            acc_next[8*pidx_reg +: 8] = pin_reg ? rdata_reg : 8'h00;
        end
        unique case (it_reg.size)
            rvie_pkg::SZ_B: ldv = it_reg.sgn ? {{56{acc_next[7]}}, acc_next[7:0]}
                                             : {56'd0, acc_next[7:0]};
            rvie_pkg::SZ_H: ldv = it_reg.sgn ? {{48{acc_next[15]}}, acc_next[15:0]}
                                             : {48'd0, acc_next[15:0]};
            rvie_pkg::SZ_W: ldv = it_reg.sgn ? {{32{acc_next[31]}}, acc_next[31:0]}
                                             : {32'd0, acc_next[31:0]};
            rvie_pkg::SZ_D: ldv = acc_next;
        endcase

        fin_off = 64'd1;
        unique case (it_reg.cls)
            rvie_pkg::CL_ADD:  fin_val = ea_reg;
            rvie_pkg::CL_XOR:  fin_val = a_reg ^ 64'(it_reg.imm);
            rvie_pkg::CL_OR:   fin_val = a_reg | 64'(it_reg.imm);
            rvie_pkg::CL_AND:  fin_val = a_reg & 64'(it_reg.imm);
            rvie_pkg::CL_SLL:  fin_val = a_reg << it_reg.imm[5:0];
            rvie_pkg::CL_SRL:  fin_val = a_reg >> it_reg.imm[5:0];
            rvie_pkg::CL_SRA:  fin_val = 64'($signed(a_reg) >>> it_reg.imm[5:0]);
            rvie_pkg::CL_LOAD: fin_val = ldv;
            rvie_pkg::CL_JALR: begin
                fin_val = (64'(it_reg.line) + 64'd1) << 2;
                fin_off = 64'($signed(d_reg + (d_reg[63] ? 64'd3 : 64'd0)) >>> 2);
            end
            rvie_pkg::CL_SET:  fin_val = it_reg.lv;
            default:           fin_val = 64'd0;
        endcase

        fin = (state_reg == rvie_pkg::B_LWAIT) || (state_reg == rvie_pkg::B_JALR)
           || (state_reg == rvie_pkg::B_EXEC && it_reg.cls != rvie_pkg::CL_JALR);
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            rdata_reg <= mem[rel[AW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            it_reg <= q_head;
            a_reg  <= rf_reg[q_head.rs];
        end
        if (state_reg == rvie_pkg::B_ADDR) begin
            ea_reg  <= a_reg + 64'(it_reg.imm);
            acc_reg <= 64'd0;
        end else begin
            acc_reg <= acc_next;
        end
        if (state_reg == rvie_pkg::B_EXEC) begin
            d_reg <= ea_reg - (64'(it_reg.line) << 2);
        end
        pidx_reg <= cnt_reg;
        pin_reg  <= in_range;
        if (fin) begin
            out_w_reg   <= it_reg.wr;
            out_r_reg   <= it_reg.wr ? it_reg.rd : rvie_pkg::REG_ZERO;
            out_val_reg <= it_reg.wr ? fin_val : 64'd0;
            out_off_reg <= fin_off;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rvie_pkg::B_CLEAR;
            clr_reg   <= '0;
            cnt_reg   <= '0;
            pend_reg  <= 1'b0;
            out_v_reg <= 1'b0;
            for (int i = 0; i < 32; i++) rf_reg[i] <= 64'd0;
        end else begin
            state_reg <= state_next;
            if (state_reg == rvie_pkg::B_CLEAR) clr_reg <= clr_reg + 1'b1;
            pend_reg <= (state_reg == rvie_pkg::B_LOAD);
            if (state_reg == rvie_pkg::B_LOAD) cnt_reg <= cnt_reg + 3'd1;
            else cnt_reg <= 3'd0;
            if (fin) begin
                out_v_reg <= 1'b1;
                if (it_reg.wr) rf_reg[it_reg.rd] <= fin_val;
            end else if (m_ready) begin
                out_v_reg <= 1'b0;
            end
        end
    end

    a_x0_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        rf_reg[0] == 64'd0) else $error("x0 was written");

    a_no_pop_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        bstat.clearing |-> !q_pop) else $error("item popped during clear");

    a_no_we_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == rvie_pkg::B_LOAD || state_reg == rvie_pkg::B_LWAIT) |-> !mem_we)
        else $error("store write during load");

    a_rise_after_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_v_reg) |-> $past(fin)) else $error("result without finish");

endmodule

// ===== hw/rtl/rv64_itype_execute_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rv64_itype_execute_top
// RV64I I-type execute block with register file and byte data store.
// ----------------------------------------------------------------------------
// After reset the data store is cleared one byte a cycle, with s_ready low.
// A two-entry queue sits between the decoding front and the execution back.
// In the back, ALU, shift, set-register and byte-write beats pass ADDR and
// EXEC, jalr ADDR, EXEC and JALR, and loads ADDR, LOAD (one byte read per
// cycle, set by the single-byte store read port) and LWAIT.
module rv64_itype_execute_top #(
    parameter int MEM_BYTES = rvie_pkg::MEM_BYTES_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [4:0]         s_req_type,
    input  logic [4:0]         s_dest_reg,
    input  logic [4:0]         s_src_reg,
    input  logic signed [11:0] s_immediate,
    input  logic [19:0]        s_line_index,
    input  logic signed [63:0] s_load_value,
    input  logic [11:0]        s_mem_index,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_reg_written,
    output logic [4:0]         m_written_reg,
    output logic signed [63:0] m_written_value,
    output logic signed [63:0] m_jump_offset
);

    rvie_pkg::item_t        push_item, head;
    rvie_pkg::back_status_t bstat;
    logic                   push, pop, full, not_empty;

    rvie_front u_front (
        .s_valid, .s_ready, .s_req_type, .s_dest_reg, .s_src_reg, .s_immediate,
        .s_line_index, .s_load_value, .s_mem_index,
        .q_full(full), .bstat(bstat), .q_push(push), .q_item(push_item)
    );

    rvie_queue u_queue (
        .aclk, .aresetn, .push(push), .push_item(push_item), .pop(pop),
        .full(full), .not_empty(not_empty), .head(head)
    );

    rvie_back #(.MEM_BYTES(MEM_BYTES)) u_back (
        .aclk, .aresetn, .q_not_empty(not_empty), .q_head(head), .q_pop(pop),
        .bstat(bstat), .m_valid, .m_ready, .m_reg_written, .m_written_reg,
        .m_written_value, .m_jump_offset
    );

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the RV64I I-type execute block: directed and random
// beats with bursty input and stalled output, checked against an in-bench
// register file and byte store model.
// ----------------------------------------------------------------------------
module tb;

    localparam int MEMB = rvie_pkg::MEM_BYTES_DEF;
    localparam longint LIMIT = 2000000;

    typedef struct packed {
        logic [4:0]         op;
        logic [4:0]         rd;
        logic [4:0]         rs;
        logic signed [11:0] imm;
        logic [19:0]        line;
        logic [63:0]        lv;
        logic [11:0]        midx;
    } instr_t;

    typedef struct packed {
        logic        wr;
        logic [4:0]  wreg;
        logic [63:0] wval;
        logic [63:0] joff;
    } wb_t;

    logic aclk = 0;
    logic aresetn = 0;
    logic s_valid = 0;
    logic s_ready;
    logic [4:0] s_req_type = 0;
    logic [4:0] s_dest_reg = 0;
    logic [4:0] s_src_reg = 0;
    logic signed [11:0] s_immediate = 0;
    logic [19:0] s_line_index = 0;
    logic signed [63:0] s_load_value = 0;
    logic [11:0] s_mem_index = 0;
    logic m_valid;
    logic m_ready = 0;
    logic m_reg_written;
    logic [4:0] m_written_reg;
    logic signed [63:0] m_written_value;
    logic signed [63:0] m_jump_offset;

    rv64_itype_execute_top dut (.*);

    instr_t pending_instrs[$];
    wb_t    expected_wb[$];
    logic [63:0] xregs[32];
    logic [7:0]  dmem[MEMB];
    int     errors = 0;
    longint cycles = 0;
    bit     hold_for_drain = 0;
    int     gap_left = 0;
    int     burst_left = 0;

    initial forever #5 aclk = ~aclk;

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] exp);
        $display("mismatch %s: got %h exp %h at cycle %0d", what, got, exp, cycles);
        errors++;
    endtask

    function automatic logic [63:0] mem_read(input logic [63:0] addr, input int n);
        logic [63:0] rel;
        logic [63:0] v;
        rel = addr - rvie_pkg::WINDOW_BASE;
        v = '0;
        for (int i = 0; i < n; i++)
            if (rel + i < MEMB) v |= 64'(dmem[rel + i]) << (8 * i);
        return v;
    endfunction

    function automatic wb_t execute_instr(input instr_t t);
        wb_t r;
        logic [63:0] a, imm, v, ea, d, lm;
        logic [5:0] sh;
        bit w;
        a = xregs[t.rs];
        imm = 64'(t.imm);
        sh = imm[5:0];
        ea = a + imm;
        v = '0;
        d = 64'd1;
        w = 1;
        case (t.op)
            rvie_pkg::REQ_ADDI:    v = a + imm;
            rvie_pkg::REQ_XORI:    v = a ^ imm;
            rvie_pkg::REQ_ORI:     v = a | imm;
            rvie_pkg::REQ_ANDI:    v = a & imm;
            rvie_pkg::REQ_SLLI:    v = a << sh;
            rvie_pkg::REQ_SRLI:    v = a >> sh;
            rvie_pkg::REQ_SRAI:    v = $signed(a) >>> sh;
            rvie_pkg::REQ_LB: begin
                lm = mem_read(ea, 1);
                v = 64'($signed(lm[7:0]));
            end
            rvie_pkg::REQ_LH: begin
                lm = mem_read(ea, 2);
                v = 64'($signed(lm[15:0]));
            end
            rvie_pkg::REQ_LW: begin
                lm = mem_read(ea, 4);
                v = 64'($signed(lm[31:0]));
            end
            rvie_pkg::REQ_LD:      v = mem_read(ea, 8);
            rvie_pkg::REQ_LBU:     v = mem_read(ea, 1);
            rvie_pkg::REQ_LHU:     v = mem_read(ea, 2);
            rvie_pkg::REQ_LWU:     v = mem_read(ea, 4);
            rvie_pkg::REQ_JALR: begin
                d = ea - 64'(t.line) * 4;
                d = d[63] ? -((-d) >> 2) : d >> 2;
                v = (64'(t.line) + 1) * 4;
            end
            rvie_pkg::REQ_SETREG:  v = t.lv;
            rvie_pkg::REQ_MEMBYTE: begin
                w = 0;
                if (t.midx < MEMB) dmem[t.midx] = t.lv[7:0];
            end
            default:     w = 0;
        endcase
        if (t.rd == rvie_pkg::REG_ZERO) w = 0;
        if (w) xregs[t.rd] = v;
        r.wr = w;
        r.wreg = w ? t.rd : '0;
        r.wval = w ? v : '0;
        r.joff = d;
        return r;
    endfunction

    function automatic instr_t mk(input logic [4:0] op, input logic [4:0] rd,
                                  input logic [4:0] rs, input logic [11:0] imm,
                                  input logic [63:0] lv, input logic [11:0] midx);
        instr_t t;
        t.op = op; t.rd = rd; t.rs = rs; t.imm = imm;
        t.line = 20'($urandom); t.lv = lv; t.midx = midx;
        return t;
    endfunction

    function automatic logic [63:0] rnd64();
        return {$urandom, $urandom};
    endfunction

    // driver
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                expected_wb.push_back(execute_instr({s_req_type, s_dest_reg, s_src_reg,
                    s_immediate, s_line_index, s_load_value, s_mem_index}));
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    s_valid <= 0;
                end else if (pending_instrs.size() > 0 && !hold_for_drain) begin
                    instr_t t;
                    t = pending_instrs.pop_front();
                    s_valid <= 1;
                    {s_req_type, s_dest_reg, s_src_reg, s_immediate, s_line_index,
                     s_load_value, s_mem_index} <= t;
                    if (burst_left > 0) burst_left <= burst_left - 1;
                    else begin
                        burst_left <= $urandom_range(0, 20);
                        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end else s_valid <= 0;
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_wb.size() == 0) begin
                    report("unexpected beat", m_written_value, 0);
                end else begin
                    wb_t e;
                    e = expected_wb.pop_front();
                    if (m_reg_written !== e.wr) report("reg_written", m_reg_written, e.wr);
                    if (m_written_reg !== e.wreg) report("written_reg", m_written_reg, e.wreg);
                    if (m_written_value !== e.wval)
                        report("written_value", m_written_value, e.wval);
                    if (m_jump_offset !== e.joff) report("jump_offset", m_jump_offset, e.joff);
                end
            end
            case ((cycles / 300) % 3)
                0: m_ready <= 1;
                1: m_ready <= ($urandom_range(0, 3) != 0);
                default: m_ready <= ($urandom_range(0, 5) == 0);
            endcase
        end
    end

    initial begin
        instr_t t;
        int op;
        for (int i = 0; i < 32; i++) xregs[i] = '0;
        for (int i = 0; i < MEMB; i++) dmem[i] = '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1;

        // directed: state load, edge fields, every op, x0, window edges
        pending_instrs.push_back(mk(rvie_pkg::REQ_SETREG, 1, 0, 0, 64'h8000_0000_0000_0000, 0));
        pending_instrs.push_back(mk(rvie_pkg::REQ_SETREG, 2, 0, 0, 64'h0000_0000_0001_0000, 0));
        pending_instrs.push_back(mk(rvie_pkg::REQ_SETREG, 3, 0, 0, 64'h0000_0000_0001_0FFC, 0));
        pending_instrs.push_back(mk(rvie_pkg::REQ_SETREG, 0, 0, 0, 64'hFFFF_FFFF_FFFF_FFFF, 0));
        for (int i = 0; i < 8; i++)
            pending_instrs.push_back(mk(rvie_pkg::REQ_MEMBYTE, 0, 0, 0, 64'h80 + i * 17,
                12'(i)));
        pending_instrs.push_back(mk(rvie_pkg::REQ_MEMBYTE, 0, 0, 0, 64'hFF, 12'hFFF));
        for (int o = rvie_pkg::REQ_ADDI; o <= rvie_pkg::REQ_JALR; o++)
            pending_instrs.push_back(mk(5'(o), 5'(4 + o), (o >= rvie_pkg::REQ_LB) ? 5'd2 : 5'd1,
                (o == rvie_pkg::REQ_SRLI) ? 12'd0 : ((o & 1) ? 12'h800 : 12'h7FF), 0, 0));
        pending_instrs.push_back(mk(rvie_pkg::REQ_LD, 30, 3, 12'd0, 0, 0));
        pending_instrs.push_back(mk(rvie_pkg::REQ_JALR, 0, 0, 12'h800, 0, 0));
        pending_instrs.push_back(mk(5'd31, 31, 31, 12'hFFF, rnd64(), 12'hFFF));
        pending_instrs.push_back(mk(rvie_pkg::REQ_SRAI, 31, 1, 12'd63, 0, 0));
        wait (pending_instrs.size() == 0);

        hold_for_drain = 1;
        wait (expected_wb.size() == 0 && !s_valid);
        hold_for_drain = 0;

        for (int i = 0; i < 600; i++) begin
            op = $urandom_range(0, 19);
            t.op = (op == 19) ? 5'($urandom_range(17, 31)) : 5'(op);
            if (op == 18) t.op = rvie_pkg::REQ_SETREG;
            t.rd = 5'($urandom);
            t.rs = 5'($urandom);
            t.imm = 12'($urandom);
            t.line = ($urandom_range(0, 1)) ? 20'($urandom) : 20'($urandom_range(0, 64));
            t.lv = rnd64();
            t.midx = ($urandom_range(0, 3) == 0) ? 12'($urandom) : 12'($urandom_range(0, 63));
            if (t.op == rvie_pkg::REQ_SETREG && $urandom_range(0, 1))
                t.lv = rvie_pkg::WINDOW_BASE + $urandom_range(0, MEMB + 8) - 4;
            if (t.op >= rvie_pkg::REQ_LB && t.op <= rvie_pkg::REQ_LWU
                && $urandom_range(0, 2) != 0)
                t.imm = 12'($urandom_range(0, 80));
            pending_instrs.push_back(t);
        end
        wait (pending_instrs.size() == 0);
        wait (expected_wb.size() == 0 && !s_valid);
        repeat (40) @(posedge aclk);
        if (errors == 0) $display("Regression PASS");
        else $display("Regression FAIL");
        $finish;
    end

    initial begin
        wait (cycles >= LIMIT);
        $display("Regression FAIL");
        $finish;
    end
endmodule
